[rtl/sprite_table_dma_and_access_gate_defines.svh]
// Assertion macros shared by the checker of the sprite-table DMA block.
`ifndef SPRITE_TABLE_DMA_AND_ACCESS_GATE_DEFINES_SVH
`define SPRITE_TABLE_DMA_AND_ACCESS_GATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STDMA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stdma port check failed");

// Next-cycle implication, checked outside reset.
`define STDMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stdma port check failed");

`endif

[rtl/stdma_pkg.sv]
// Types, codes and address decode helpers of the sprite-table DMA block.
package stdma_pkg;

    // Command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PAGE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    // Requester codes.
    localparam logic [1:0] REQ_CPU = 2'd0;
    localparam logic [1:0] REQ_DMA = 2'd2;

    // Video mode codes.
    localparam logic [1:0] MODE_SCAN = 2'd2;
    localparam logic [1:0] MODE_DRAW = 2'd3;

    // Region codes.
    localparam logic [1:0] REGION_ROM      = 2'd0;
    localparam logic [1:0] REGION_CART_RAM = 2'd1;
    localparam logic [1:0] REGION_ECHO     = 2'd2;
    localparam logic [1:0] REGION_INTERNAL = 2'd3;

    // Engine constants.
    localparam logic [1:0]  START_DELAY     = 2'd2;
    localparam logic [7:0]  PAGE_RESET      = 8'hFF;
    localparam logic [7:0]  PAGE_ECHO_MIN   = 8'hFE;
    localparam logic [7:0]  PAGE_ECHO_SHIFT = 8'h20;
    localparam logic [7:0]  END_LOW_BYTE    = 8'hA0;
    localparam logic [7:0]  TABLE_PAGE      = 8'hFE;
    localparam logic [15:0] ECHO_OFFSET     = 16'h2000;

    // Engine state seen by the access gate.
    typedef struct packed {
        logic active;
        logic vram_blocked;
        logic outer_blocked;
    } dma_state_t;

    // Access check answer.
    typedef struct packed {
        logic        blocked;
        logic [1:0]  region;
        logic [15:0] mapped;
    } access_t;

    // One result word.
    typedef struct packed {
        logic        dma_busy;
        logic        copy_valid;
        logic [15:0] copy_source;
        logic [15:0] copy_target;
        logic        access_blocked;
        logic [1:0]  region;
        logic [15:0] mapped_address;
        logic [7:0]  page_register;
    } result_t;

    // Video RAM, 0x8000 to 0x9FFF.
    function automatic logic in_vram(input logic [15:0] a);
        return a[15:13] == 3'b100;
    endfunction

    // Sprite table, 0xFE00 to 0xFE9F.
    function automatic logic in_table(input logic [15:0] a);
        return (a[15:8] == TABLE_PAGE) && (a[7:0] < END_LOW_BYTE);
    endfunction

    // External bus, 0x0000 to 0x7FFF and 0xA000 to 0xFDFF.
    function automatic logic in_outer(input logic [15:0] a);
        return (a[15] == 1'b0) || (a[15:13] == 3'b101) || (a[15:13] == 3'b110)
            || ((a[15:13] == 3'b111) && (a[15:9] != 7'h7F));
    endfunction

endpackage

[rtl/stdma_gate.sv]
// Bus access gate: region decode, echo mapping and blocking decision.
module stdma_gate
    import stdma_pkg::*;
(
    input  logic [15:0] address,
    input  logic [1:0]  requester,
    input  logic [1:0]  ppu_mode,
    input  dma_state_t  dma_state,
    output access_t     access
);

    logic       oam_hit;
    logic       vram_hit;
    logic       dma_block;
    logic       cpu_block;
    logic [1:0] region_sel;

    // Region decode.
    always_comb
    begin
        if (address[15] == 1'b0)
            region_sel = REGION_ROM;
        else if (address[15:13] == 3'b101)
            region_sel = REGION_CART_RAM;
        else if ((address[15:13] == 3'b111) && (address[15:9] != 7'h7F))
            region_sel = REGION_ECHO;
        else
            region_sel = REGION_INTERNAL;
    end

    // Blocking by a running transfer, then by the video mode.
    assign oam_hit  = in_table(address);
    assign vram_hit = in_vram(address);
    assign dma_block = dma_state.active && (requester != REQ_DMA)
        && (oam_hit || (dma_state.vram_blocked && vram_hit)
            || (dma_state.outer_blocked && in_outer(address)));
    assign cpu_block = (region_sel == REGION_INTERNAL) && (requester == REQ_CPU)
        && ((oam_hit && ((ppu_mode == MODE_SCAN) || (ppu_mode == MODE_DRAW)))
            || (vram_hit && (ppu_mode == MODE_DRAW)));

    // Echo accesses fold down onto work RAM.
    assign access = '{blocked: dma_block || cpu_block,
                      region:  region_sel,
                      mapped:  (region_sel == REGION_ECHO) ? (address - ECHO_OFFSET)
                                                          : address};

endmodule

[rtl/stdma_skid.sv]
// Result register with a skid stage so input can be taken while output stalls.
module stdma_skid
    import stdma_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            main_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Result words.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !take)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

[rtl/sprite_table_dma_and_access_gate.sv]
// Each accepted word's result is registered in the result stage.
// Throughput: one word per cycle while in_stall is low; the engine state updates in one pass per word.
// A two-entry result stage takes new words while the output stalls, until both entries are full.
// Reset is asynchronous: page register 0xFF, delay, transfer, source and
// block marks cleared, no result pending.
module sprite_table_dma_and_access_gate
    import stdma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_value,
    input  logic [15:0] address,
    input  logic [1:0]  requester,
    input  logic [1:0]  ppu_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        dma_busy,
    output logic        copy_valid,
    output logic [15:0] copy_source,
    output logic [15:0] copy_target,
    output logic        access_blocked,
    output logic [1:0]  region,
    output logic [15:0] mapped_address,
    output logic [7:0]  page_register
);

    logic [7:0]  page_reg, page_next;
    logic [1:0]  delay_reg, delay_next;
    logic        active_reg, active_next;
    logic [15:0] source_reg, source_next;
    logic        vram_blk_reg, vram_blk_next;
    logic        outer_blk_reg, outer_blk_next;

    logic        accept;
    logic        full;
    logic        start;
    logic [7:0]  start_page;
    logic [15:0] src_a;
    logic [15:0] src_b;
    logic [15:0] src_c;
    logic        active_a;
    dma_state_t  dma_state;
    access_t     access;
    result_t     result;
    result_t     out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Access check against the state before this word.
    assign dma_state = '{active: active_reg, vram_blocked: vram_blk_reg,
                         outer_blocked: outer_blk_reg};

    stdma_gate u_gate (
        .address   (address),
        .requester (requester),
        .ppu_mode  (ppu_mode),
        .dma_state (dma_state),
        .access    (access)
    );

    // Start address of a transfer; the two top pages fold onto work RAM.
    assign start      = (delay_reg == 2'd1);
    assign start_page = (page_reg >= PAGE_ECHO_MIN) ? (page_reg - PAGE_ECHO_SHIFT) : page_reg;
    assign src_a      = start ? {start_page, 8'h00} : source_reg;
    assign active_a   = start || active_reg;
    assign src_b      = (src_a[7:0] == END_LOW_BYTE) ? 16'h0000 : src_a;
    assign src_c      = src_b + 16'd1;

    // Next engine state and result word.
    always_comb
    begin
        page_next      = page_reg;
        delay_next     = delay_reg;
        active_next    = active_reg;
        source_next    = source_reg;
        vram_blk_next  = vram_blk_reg;
        outer_blk_next = outer_blk_reg;
        result         = '0;
        unique case (command)
            CMD_TICK:
            begin
                if (delay_reg != 2'd0)
                    delay_next = delay_reg - 2'd1;
                active_next = active_a;
                source_next = src_a;
                if (src_a[7:0] == END_LOW_BYTE)
                begin
                    active_next    = 1'b0;
                    source_next    = 16'h0000;
                    vram_blk_next  = 1'b0;
                    outer_blk_next = 1'b0;
                end
                if (active_next)
                begin
                    result.copy_valid  = 1'b1;
                    result.copy_source = src_b;
                    result.copy_target = {TABLE_PAGE, src_b[7:0]};
                    source_next        = src_c;
                    vram_blk_next      = in_vram(src_c);
                    outer_blk_next     = in_outer(src_c);
                end
            end
            CMD_PAGE:
            begin
                page_next  = data_value;
                delay_next = START_DELAY;
            end
            CMD_CHECK:
            begin
                result.access_blocked = access.blocked;
                result.region         = access.region;
                result.mapped_address = access.mapped;
            end
            default:
            begin
            end
        endcase
        result.dma_busy      = active_next;
        result.page_register = page_next;
    end

    // Engine state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg      <= PAGE_RESET;
            delay_reg     <= 2'd0;
            active_reg    <= 1'b0;
            source_reg    <= 16'h0000;
            vram_blk_reg  <= 1'b0;
            outer_blk_reg <= 1'b0;
        end
        else if (accept)
        begin
            page_reg      <= page_next;
            delay_reg     <= delay_next;
            active_reg    <= active_next;
            source_reg    <= source_next;
            vram_blk_reg  <= vram_blk_next;
            outer_blk_reg <= outer_blk_next;
        end
    end

    // Result stage.
    stdma_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign dma_busy       = out_data.dma_busy;
    assign copy_valid     = out_data.copy_valid;
    assign copy_source    = out_data.copy_source;
    assign copy_target    = out_data.copy_target;
    assign access_blocked = out_data.access_blocked;
    assign region         = out_data.region;
    assign mapped_address = out_data.mapped_address;
    assign page_register  = out_data.page_register;

endmodule

[rtl/stdma_checker.sv]
// Port-level checks of the sprite-table DMA block and their binding.
`include "sprite_table_dma_and_access_gate_defines.svh"

module stdma_checker
    import stdma_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        dma_busy,
    input logic        copy_valid,
    input logic [15:0] copy_source,
    input logic [15:0] copy_target,
    input logic [1:0]  region,
    input logic [15:0] mapped_address,
    input logic [7:0]  page_register
);

    // A copy request leaves the transfer running.
    `STDMA_ASSERT_SAME(a_copy_busy, clk, rst_n, out_valid && copy_valid, dma_busy)

    // A copy writes inside the sprite table, at the low byte of its source.
    `STDMA_ASSERT_SAME(a_copy_target, clk, rst_n, out_valid && copy_valid, (copy_target[15:8] == TABLE_PAGE) && (copy_target[7:0] == copy_source[7:0]) && (copy_target[7:0] < END_LOW_BYTE))

    // An echo access maps into work RAM, 0xC000 to 0xDDFF.
    `STDMA_ASSERT_SAME(a_echo_map, clk, rst_n, out_valid && (region == REGION_ECHO), (mapped_address[15:14] == 2'b11) && (mapped_address[13] == 1'b0))

    // A stalled result word holds.
    `STDMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(copy_source) && $stable(mapped_address) && $stable(page_register))

endmodule

bind sprite_table_dma_and_access_gate stdma_checker u_checker (.*);
